// File: rtl/edbs_pkg.sv
// Shared types and constants for the echo-detect blink scheduler.
package edbs_pkg;

	localparam int PERIOD_W    = 15;
	localparam int PING_W      = 8;
	localparam int THRESH_W    = 21;
	localparam int OFFSET_W    = 10;
	localparam int BLINK_W     = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 21;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ECHO = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_ON_PERIOD       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEARTBEAT_OFF   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DETECTED_OFF    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PING_PERIOD     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MAG_THRESHOLD   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_OFFSET     = 3'd5;

	localparam logic [PERIOD_W-1:0] RST_ON_PERIOD     = 15'd40;
	localparam logic [PERIOD_W-1:0] RST_HEARTBEAT_OFF = 15'd960;
	localparam logic [PERIOD_W-1:0] RST_DETECTED_OFF  = 15'd160;
	localparam logic [PING_W-1:0]   RST_PING_PERIOD   = 8'd30;
	localparam logic [THRESH_W-1:0] RST_MAG_THRESHOLD = 21'd5000;
	localparam logic [OFFSET_W-1:0] RST_IDLE_OFFSET   = 10'd0;

	// Timing and threshold settings seen by the scheduler stage
	typedef struct packed {
		logic [PERIOD_W-1:0] on_period;
		logic [PERIOD_W-1:0] heartbeat_off_period;
		logic [PERIOD_W-1:0] detected_off_period;
		logic [PING_W-1:0]   ping_period;
		logic [THRESH_W-1:0] magnitude_threshold;
	} sched_cfg_t;

	// Control travelling with the lane results
	typedef struct packed {
		logic valid;
		logic opcode;
	} stage_ctrl_t;

endpackage

// File: rtl/edbs_cfg.sv
// Configuration register file for the echo-detect blink scheduler.
module edbs_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic [edbs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [edbs_pkg::CFG_DATA_W-1:0]   cfg_data,
	output edbs_pkg::sched_cfg_t              sched_cfg,
	output logic [edbs_pkg::OFFSET_W-1:0]     idle_offset
);

	edbs_pkg::sched_cfg_t              cfg_q;
	logic [edbs_pkg::OFFSET_W-1:0]     idle_offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_period            <= edbs_pkg::RST_ON_PERIOD;
			cfg_q.heartbeat_off_period <= edbs_pkg::RST_HEARTBEAT_OFF;
			cfg_q.detected_off_period  <= edbs_pkg::RST_DETECTED_OFF;
			cfg_q.ping_period          <= edbs_pkg::RST_PING_PERIOD;
			cfg_q.magnitude_threshold  <= edbs_pkg::RST_MAG_THRESHOLD;
			idle_offset_q              <= edbs_pkg::RST_IDLE_OFFSET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				edbs_pkg::REG_ON_PERIOD:
					cfg_q.on_period <= cfg_data[edbs_pkg::PERIOD_W-1:0];
				edbs_pkg::REG_HEARTBEAT_OFF:
					cfg_q.heartbeat_off_period <= cfg_data[edbs_pkg::PERIOD_W-1:0];
				edbs_pkg::REG_DETECTED_OFF:
					cfg_q.detected_off_period <= cfg_data[edbs_pkg::PERIOD_W-1:0];
				edbs_pkg::REG_PING_PERIOD:
					cfg_q.ping_period <= cfg_data[edbs_pkg::PING_W-1:0];
				edbs_pkg::REG_MAG_THRESHOLD:
					cfg_q.magnitude_threshold <= cfg_data[edbs_pkg::THRESH_W-1:0];
				edbs_pkg::REG_IDLE_OFFSET:
					idle_offset_q <= cfg_data[edbs_pkg::OFFSET_W-1:0];
				default: ; // drop writes to unmapped indexes
			endcase
		end
	end

	assign sched_cfg   = cfg_q;
	assign idle_offset = idle_offset_q;

endmodule

// File: rtl/edbs_lane.sv
// One echo lane: remove the DC offset from a sample and register its square.
module edbs_lane #(
	parameter int SAMPLE_BITS = 10,
	parameter int DEV_W       = 11
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [SAMPLE_BITS-1:0]        sample,
	input  logic [edbs_pkg::OFFSET_W-1:0] idle_offset,
	output logic [2*DEV_W-1:0]            square_s1
);

	logic signed [DEV_W-1:0]   sample_ext;
	logic signed [DEV_W-1:0]   offset_ext;
	logic signed [DEV_W-1:0]   deviation;
	logic signed [2*DEV_W-1:0] product;

	assign sample_ext = $signed(DEV_W'(sample));
	assign offset_ext = $signed(DEV_W'(idle_offset));
	assign deviation  = sample_ext - offset_ext;
	assign product    = deviation * deviation;

	always_ff @(posedge clk) begin
		if (en) begin
			square_s1 <= $unsigned(product);
		end
	end

endmodule

// File: rtl/edbs_sched.sv
// Merge of the lane squares, detection, and blink/ping scheduling with output register.
module edbs_sched #(
	parameter int SQ_W = 22
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  logic                 out_stall,
	input  edbs_pkg::stage_ctrl_t ctrl_s1,
	input  logic [SQ_W-1:0]      first_square_s1,
	input  logic [SQ_W-1:0]      second_square_s1,
	input  edbs_pkg::sched_cfg_t sched_cfg,
	output logic                 out_valid,
	output logic                 led_level,
	output logic                 fire_ping,
	output logic                 echo_detected
);

	localparam int SUM_W = SQ_W + 1;
	localparam int CMP_W = (SUM_W > edbs_pkg::THRESH_W) ? SUM_W : edbs_pkg::THRESH_W;

	logic [SUM_W-1:0]                sum_sq;
	logic                            detected_n;
	logic [edbs_pkg::BLINK_W-1:0]    blink_inc;
	logic [edbs_pkg::PING_W-1:0]     ping_inc;
	logic [edbs_pkg::PERIOD_W-1:0]   off_period;
	logic [edbs_pkg::BLINK_W-1:0]    blink_n;
	logic                            led_n;
	logic [edbs_pkg::PING_W-1:0]     ping_n;
	logic                            fire_n;

	logic [edbs_pkg::BLINK_W-1:0]    blink_count_q;
	logic [edbs_pkg::PING_W-1:0]     ping_count_q;
	logic                            led_lit_q;
	logic                            detected_q;
	logic                            fire_q;
	logic                            out_valid_q;

	assign sum_sq = SUM_W'(first_square_s1) + SUM_W'(second_square_s1);

	always_comb begin
		detected_n = detected_q;
		blink_inc  = blink_count_q;
		ping_inc   = ping_count_q;
		if (ctrl_s1.opcode == edbs_pkg::OP_ECHO) begin
			detected_n = CMP_W'(sum_sq) > CMP_W'(sched_cfg.magnitude_threshold);
		end else begin
			blink_inc = blink_count_q + 1'b1;
			ping_inc  = ping_count_q + 1'b1;
		end

		off_period = detected_n ? sched_cfg.detected_off_period
		                        : sched_cfg.heartbeat_off_period;
		blink_n = blink_inc;
		led_n   = led_lit_q;
		if (led_lit_q) begin
			if (blink_inc > edbs_pkg::BLINK_W'(sched_cfg.on_period)) begin
				blink_n = '0;
				led_n   = 1'b0;
			end
		end else begin
			if (blink_inc > edbs_pkg::BLINK_W'(off_period)) begin
				blink_n = '0;
				led_n   = 1'b1;
			end
		end

		ping_n = ping_inc;
		fire_n = 1'b0;
		if (ping_inc > sched_cfg.ping_period) begin
			ping_n = '0;
			fire_n = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blink_count_q <= '0;
			ping_count_q  <= '0;
			led_lit_q     <= 1'b0;
			detected_q    <= 1'b0;
			fire_q        <= 1'b0;
			out_valid_q   <= 1'b0;
		end else if (load) begin
			blink_count_q <= blink_n;
			ping_count_q  <= ping_n;
			led_lit_q     <= led_n;
			detected_q    <= detected_n;
			fire_q        <= fire_n;
			out_valid_q   <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q   <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign led_level     = led_lit_q;
	assign fire_ping     = fire_q;
	assign echo_detected = detected_q;

	a_fire_clears_ping: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && fire_q) |-> (ping_count_q == '0))
		else $error("ping fired but ping counter not cleared");

	a_toggle_clears_blink: assert property (@(posedge clk) disable iff (!arst_n)
		(led_lit_q != $past(led_lit_q)) |-> (blink_count_q == '0))
		else $error("indicator toggled without clearing blink counter");

	a_result_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(ctrl_s1.valid))
		else $error("result appeared without an item in the lane stage");

	a_load_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> ctrl_s1.valid)
		else $error("scheduler state advanced with no item");

endmodule

// File: rtl/echo_detect_blink_scheduler_core.sv
// Top level of the echo-detect blink scheduler.
// Takes one item per clock cycle while in_stall is low. The lane stage registers the
// two lane squares (one multiplier per sample); the scheduler stage sums them, compares with
// the threshold and updates the blink and ping counters into the output register, so the
// state loop closes at that register and items follow each other back to back. A result
// waiting under out_stall still lets one more item enter the lane stage. Configuration
// writes are always taken (cfg_ready is tied high) and must be made while the block is idle.
module echo_detect_blink_scheduler_core #(
	parameter int SAMPLE_BITS = 10
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             opcode,
	input  logic [SAMPLE_BITS-1:0]           first_sample,
	input  logic [SAMPLE_BITS-1:0]           second_sample,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             led_level,
	output logic                             fire_ping,
	output logic                             echo_detected,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [edbs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [edbs_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int DEV_W = ((SAMPLE_BITS > edbs_pkg::OFFSET_W) ? SAMPLE_BITS
	                                                           : edbs_pkg::OFFSET_W) + 1;
	localparam int SQ_W  = 2 * DEV_W;

	edbs_pkg::sched_cfg_t          sched_cfg;
	logic [edbs_pkg::OFFSET_W-1:0] idle_offset;
	edbs_pkg::stage_ctrl_t         ctrl_s1;
	logic [SQ_W-1:0]               first_square_s1;
	logic [SQ_W-1:0]               second_square_s1;
	logic                          s2_load;
	logic                          s1_en;

	// Output register frees when empty or when its result transfers this cycle
	assign s2_load  = ctrl_s1.valid && (!out_valid || !out_stall);
	assign s1_en    = !ctrl_s1.valid || s2_load;
	assign in_stall = !s1_en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (s1_en) begin
			ctrl_s1.valid  <= in_valid;
			ctrl_s1.opcode <= opcode;
		end
	end

	edbs_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.sched_cfg   (sched_cfg),
		.idle_offset (idle_offset)
	);

	edbs_lane #(.SAMPLE_BITS(SAMPLE_BITS), .DEV_W(DEV_W)) u_lane_first (
		.clk         (clk),
		.en          (s1_en),
		.sample      (first_sample),
		.idle_offset (idle_offset),
		.square_s1   (first_square_s1)
	);

	edbs_lane #(.SAMPLE_BITS(SAMPLE_BITS), .DEV_W(DEV_W)) u_lane_second (
		.clk         (clk),
		.en          (s1_en),
		.sample      (second_sample),
		.idle_offset (idle_offset),
		.square_s1   (second_square_s1)
	);

	edbs_sched #(.SQ_W(SQ_W)) u_sched (
		.clk              (clk),
		.arst_n           (arst_n),
		.load             (s2_load),
		.out_stall        (out_stall),
		.ctrl_s1          (ctrl_s1),
		.first_square_s1  (first_square_s1),
		.second_square_s1 (second_square_s1),
		.sched_cfg        (sched_cfg),
		.out_valid        (out_valid),
		.led_level        (led_level),
		.fire_ping        (fire_ping),
		.echo_detected    (echo_detected)
	);

endmodule

// File: verif/tb_echo_detect_blink_scheduler_core.sv
// Self-checking testbench for the echo-detect blink scheduler core.
module tb_echo_detect_blink_scheduler_core;

	localparam int SAMPLE_W      = 10;
	localparam int SAMPLE_MAX    = (1 << SAMPLE_W) - 1;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 210;
	localparam int TICK_PCT      = 65;
	localparam int SETTLE_CYCLES = 6;
	localparam int LONG_HOLD     = 300;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int THRESH_MAX    = (1 << edbs_pkg::THRESH_W) - 1;
	localparam int SQ_SUM_MAX    = 2 * SAMPLE_MAX * SAMPLE_MAX;

	// Indexes beyond the register file; writes to them must be ignored
	localparam logic [edbs_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [edbs_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	typedef struct packed {
		logic                opcode;
		logic [SAMPLE_W-1:0] first_sample;
		logic [SAMPLE_W-1:0] second_sample;
	} echo_item_t;

	typedef struct packed {
		logic led_level;
		logic fire_ping;
		logic echo_detected;
	} indication_t;

	logic                            clk           = 1'b0;
	logic                            arst_n        = 1'b0;
	logic                            in_valid      = 1'b0;
	logic                            in_stall;
	logic                            opcode        = edbs_pkg::OP_TICK;
	logic [SAMPLE_W-1:0]             first_sample  = '0;
	logic [SAMPLE_W-1:0]             second_sample = '0;
	logic                            out_valid;
	logic                            out_stall     = 1'b0;
	logic                            led_level;
	logic                            fire_ping;
	logic                            echo_detected;
	logic                            cfg_valid     = 1'b0;
	logic                            cfg_ready;
	logic [edbs_pkg::CFG_IDX_W-1:0]  cfg_index     = edbs_pkg::REG_ON_PERIOD;
	logic [edbs_pkg::CFG_DATA_W-1:0] cfg_data      = '0;

	echo_item_t  item_queue[$];
	indication_t awaited_indications[$];
	int unsigned items_queued  = 0;
	int unsigned items_taken   = 0;
	int unsigned mismatches    = 0;
	int unsigned cycle_count   = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct     = 0;
	logic        in_took       = 1'b0;
	logic        cfg_took      = 1'b0;
	logic        hold_go       = 1'b0;
	logic        hold_seen     = 1'b0;
	int unsigned hold_left     = 0;

	// Scheduler state and settings as the block should hold them
	logic [edbs_pkg::BLINK_W-1:0]  blink_ticks;
	logic                          lamp_lit;
	logic [edbs_pkg::PING_W-1:0]   ping_ticks;
	logic                          echo_seen;
	logic [edbs_pkg::PERIOD_W-1:0] lit_ticks;
	logic [edbs_pkg::PERIOD_W-1:0] heartbeat_ticks;
	logic [edbs_pkg::PERIOD_W-1:0] detected_ticks;
	logic [edbs_pkg::PING_W-1:0]   ping_interval;
	logic [edbs_pkg::THRESH_W-1:0] echo_threshold;
	logic [edbs_pkg::OFFSET_W-1:0] idle_level;

	echo_detect_blink_scheduler_core #(.SAMPLE_BITS(SAMPLE_W)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.first_sample  (first_sample),
		.second_sample (second_sample),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.led_level     (led_level),
		.fire_ping     (fire_ping),
		.echo_detected (echo_detected),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic void apply_setting(logic [edbs_pkg::CFG_IDX_W-1:0] idx,
		logic [edbs_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			edbs_pkg::REG_ON_PERIOD:     lit_ticks       = data[edbs_pkg::PERIOD_W-1:0];
			edbs_pkg::REG_HEARTBEAT_OFF: heartbeat_ticks = data[edbs_pkg::PERIOD_W-1:0];
			edbs_pkg::REG_DETECTED_OFF:  detected_ticks  = data[edbs_pkg::PERIOD_W-1:0];
			edbs_pkg::REG_PING_PERIOD:   ping_interval   = data[edbs_pkg::PING_W-1:0];
			edbs_pkg::REG_MAG_THRESHOLD: echo_threshold  = data[edbs_pkg::THRESH_W-1:0];
			edbs_pkg::REG_IDLE_OFFSET:   idle_level      = data[edbs_pkg::OFFSET_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic indication_t schedule_step(echo_item_t it);
		indication_t                   r;
		longint                        dev_a;
		longint                        dev_b;
		logic [edbs_pkg::PERIOD_W-1:0] dark_ticks;
		r.fire_ping = 1'b0;
		if (it.opcode == edbs_pkg::OP_TICK) begin
			blink_ticks = blink_ticks + 1'b1;
			ping_ticks  = ping_ticks + 1'b1;
		end else begin
			dev_a     = longint'(it.first_sample) - longint'(idle_level);
			dev_b     = longint'(it.second_sample) - longint'(idle_level);
			echo_seen = (dev_a * dev_a + dev_b * dev_b) > longint'(echo_threshold);
		end
		dark_ticks = echo_seen ? detected_ticks : heartbeat_ticks;
		if (lamp_lit) begin
			if (blink_ticks > lit_ticks) begin
				blink_ticks = '0;
				lamp_lit    = 1'b0;
			end
		end else if (blink_ticks > dark_ticks) begin
			blink_ticks = '0;
			lamp_lit    = 1'b1;
		end
		if (ping_ticks > ping_interval) begin
			ping_ticks  = '0;
			r.fire_ping = 1'b1;
		end
		r.led_level     = lamp_lit;
		r.echo_detected = echo_seen;
		return r;
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		int v;
		if ($urandom_range(1) == 0)
			return SAMPLE_W'($urandom_range(SAMPLE_MAX));
		// cluster around the idle level so both sides of the threshold are hit
		v = int'(idle_level) + int'($urandom_range(160)) - 80;
		if (v < 0)
			v = 0;
		if (v > SAMPLE_MAX)
			v = SAMPLE_MAX;
		return SAMPLE_W'(v);
	endfunction

	task automatic queue_item(logic op, int unsigned a, int unsigned b);
		echo_item_t it;
		it.opcode        = op;
		it.first_sample  = SAMPLE_W'(a);
		it.second_sample = SAMPLE_W'(b);
		item_queue.push_back(it);
		items_queued++;
	endtask

	task automatic queue_random_item();
		logic op;
		op = ($urandom_range(99) < TICK_PCT) ? edbs_pkg::OP_TICK : edbs_pkg::OP_ECHO;
		queue_item(op, pick_sample(), pick_sample());
	endtask

	// Random junk above the register width must be ignored
	task automatic write_reg(logic [edbs_pkg::CFG_IDX_W-1:0] idx, int unsigned value,
		int width);
		logic [edbs_pkg::CFG_DATA_W-1:0] word;
		int                              b;
		word = edbs_pkg::CFG_DATA_W'($urandom);
		for (b = 0; b < width && b < edbs_pkg::CFG_DATA_W; b++)
			word[b] = value[b];
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		do
			@(negedge clk);
		while (!cfg_took);
		cfg_valid <= 1'b0;
	endtask

	task automatic program_phase(int p);
		case (p)
			0: begin
				write_reg(edbs_pkg::REG_ON_PERIOD, 3, edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_HEARTBEAT_OFF, 12, edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_DETECTED_OFF, 2, edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_PING_PERIOD, 5, edbs_pkg::PING_W);
				write_reg(edbs_pkg::REG_MAG_THRESHOLD, 4000, edbs_pkg::THRESH_W);
				write_reg(edbs_pkg::REG_IDLE_OFFSET, 512, edbs_pkg::OFFSET_W);
			end
			1: begin
				write_reg(edbs_pkg::REG_ON_PERIOD, 0, edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_HEARTBEAT_OFF, 0, edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_DETECTED_OFF, 0, edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_PING_PERIOD, 0, edbs_pkg::PING_W);
				write_reg(edbs_pkg::REG_MAG_THRESHOLD, 0, edbs_pkg::THRESH_W);
				write_reg(edbs_pkg::REG_IDLE_OFFSET, 0, edbs_pkg::OFFSET_W);
			end
			2: begin
				// long ping period lets the count build up for the next phase
				write_reg(edbs_pkg::REG_ON_PERIOD, $urandom_range(15), edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_HEARTBEAT_OFF, $urandom_range(40), edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_DETECTED_OFF, $urandom_range(6), edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_PING_PERIOD, 200, edbs_pkg::PING_W);
				write_reg(edbs_pkg::REG_MAG_THRESHOLD, $urandom_range(30000),
					edbs_pkg::THRESH_W);
				write_reg(edbs_pkg::REG_IDLE_OFFSET, $urandom_range(SAMPLE_MAX),
					edbs_pkg::OFFSET_W);
			end
			3: begin
				write_reg(edbs_pkg::REG_ON_PERIOD, $urandom_range(10), edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_HEARTBEAT_OFF, $urandom_range(30), edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_DETECTED_OFF, $urandom_range(4), edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_PING_PERIOD, 2, edbs_pkg::PING_W);
				write_reg(edbs_pkg::REG_MAG_THRESHOLD, THRESH_MAX, edbs_pkg::THRESH_W);
				write_reg(edbs_pkg::REG_IDLE_OFFSET, SAMPLE_MAX, edbs_pkg::OFFSET_W);
			end
			4: begin
				// ping counter wraps and never fires at the top code
				write_reg(edbs_pkg::REG_ON_PERIOD, (1 << edbs_pkg::PERIOD_W) - 1,
					edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_HEARTBEAT_OFF, (1 << edbs_pkg::PERIOD_W) - 1,
					edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_DETECTED_OFF, (1 << edbs_pkg::PERIOD_W) - 1,
					edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_PING_PERIOD, (1 << edbs_pkg::PING_W) - 1,
					edbs_pkg::PING_W);
				write_reg(edbs_pkg::REG_MAG_THRESHOLD, $urandom_range(SQ_SUM_MAX),
					edbs_pkg::THRESH_W);
				write_reg(edbs_pkg::REG_IDLE_OFFSET, $urandom_range(SAMPLE_MAX),
					edbs_pkg::OFFSET_W);
			end
			5: begin
				write_reg(edbs_pkg::REG_ON_PERIOD, 1, edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_HEARTBEAT_OFF, 30, edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_DETECTED_OFF, 1, edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_PING_PERIOD, (1 << edbs_pkg::PING_W) - 2,
					edbs_pkg::PING_W);
				write_reg(edbs_pkg::REG_MAG_THRESHOLD, $urandom_range(20000),
					edbs_pkg::THRESH_W);
				write_reg(edbs_pkg::REG_IDLE_OFFSET, $urandom_range(SAMPLE_MAX),
					edbs_pkg::OFFSET_W);
			end
			default: begin
				write_reg(edbs_pkg::REG_ON_PERIOD, $urandom_range(12), edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_HEARTBEAT_OFF, $urandom_range(50), edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_DETECTED_OFF, $urandom_range(8), edbs_pkg::PERIOD_W);
				write_reg(edbs_pkg::REG_PING_PERIOD, $urandom_range(20), edbs_pkg::PING_W);
				write_reg(edbs_pkg::REG_MAG_THRESHOLD, $urandom_range(25000),
					edbs_pkg::THRESH_W);
				write_reg(edbs_pkg::REG_IDLE_OFFSET, $urandom_range(SAMPLE_MAX),
					edbs_pkg::OFFSET_W);
				if (p == PHASES - 1) begin
					write_reg(REG_SPARE_LO, $urandom, edbs_pkg::CFG_DATA_W);
					write_reg(REG_SPARE_HI, $urandom, edbs_pkg::CFG_DATA_W);
				end
			end
		endcase
	endtask

	task automatic wait_idle();
		while (items_taken != items_queued || awaited_indications.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Input driver: offer the next item once the current one has transferred
	always @(negedge clk) begin : drive_items
		echo_item_t nxt;
		if (!in_valid || in_took) begin
			if (item_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = item_queue.pop_front();
				in_valid      <= 1'b1;
				opcode        <= nxt.opcode;
				first_sample  <= nxt.first_sample;
				second_sample <= nxt.second_sample;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Output back-pressure, with an occasional long hold-off
	always @(negedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// Monitor: check results, track settings, predict from accepted items
	always @(posedge clk) begin : watch_block
		indication_t want;
		echo_item_t  got_item;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycle_count);
			$display("FAIL echo_detect_blink_scheduler_core");
			$finish;
		end else begin
			in_took  <= arst_n && in_valid && !in_stall;
			cfg_took <= arst_n && cfg_valid && cfg_ready;
			if (arst_n) begin
				if (out_valid && !out_stall) begin
					if (awaited_indications.size() == 0) begin
						mismatches++;
						$display("%0t: result with none awaited, got led %0b ping %0b echo %0b",
							$time, led_level, fire_ping, echo_detected);
					end else begin
						want = awaited_indications.pop_front();
						if (led_level !== want.led_level) begin
							mismatches++;
							$display("%0t: led_level expected %0b got %0b",
								$time, want.led_level, led_level);
						end
						if (fire_ping !== want.fire_ping) begin
							mismatches++;
							$display("%0t: fire_ping expected %0b got %0b",
								$time, want.fire_ping, fire_ping);
						end
						if (echo_detected !== want.echo_detected) begin
							mismatches++;
							$display("%0t: echo_detected expected %0b got %0b",
								$time, want.echo_detected, echo_detected);
						end
					end
				end
				if (cfg_valid && cfg_ready)
					apply_setting(cfg_index, cfg_data);
				if (in_valid && !in_stall) begin
					got_item.opcode        = opcode;
					got_item.first_sample  = first_sample;
					got_item.second_sample = second_sample;
					awaited_indications.push_back(schedule_step(got_item));
					items_taken++;
				end
			end
		end
	end

	initial begin
		int p;
		int n;
		blink_ticks     = '0;
		lamp_lit        = 1'b0;
		ping_ticks      = '0;
		echo_seen       = 1'b0;
		lit_ticks       = edbs_pkg::RST_ON_PERIOD;
		heartbeat_ticks = edbs_pkg::RST_HEARTBEAT_OFF;
		detected_ticks  = edbs_pkg::RST_DETECTED_OFF;
		ping_interval   = edbs_pkg::RST_PING_PERIOD;
		echo_threshold  = edbs_pkg::RST_MAG_THRESHOLD;
		idle_level      = edbs_pkg::RST_IDLE_OFFSET;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// Reset settings: sample extremes and the threshold edges
		queue_item(edbs_pkg::OP_TICK, 0, 0);
		queue_item(edbs_pkg::OP_TICK, SAMPLE_MAX, SAMPLE_MAX);
		queue_item(edbs_pkg::OP_ECHO, 0, 0);
		queue_item(edbs_pkg::OP_ECHO, SAMPLE_MAX, SAMPLE_MAX);
		queue_item(edbs_pkg::OP_ECHO, SAMPLE_MAX, 0);
		queue_item(edbs_pkg::OP_ECHO, 0, SAMPLE_MAX);
		queue_item(edbs_pkg::OP_ECHO, 70, 0);
		queue_item(edbs_pkg::OP_ECHO, 71, 0);
		queue_item(edbs_pkg::OP_ECHO, 50, 50);
		queue_item(edbs_pkg::OP_ECHO, 50, 51);
		queue_item(edbs_pkg::OP_ECHO, 0, 0);
		for (n = 0; n < 12; n++)
			queue_item(edbs_pkg::OP_TICK, $urandom_range(SAMPLE_MAX),
				$urandom_range(SAMPLE_MAX));
		wait_idle();

		for (p = 0; p < PHASES; p++) begin
			@(posedge clk);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 71;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 71;
				end
				default: begin
					send_idle_pct = 17;
					stall_pct     = 17;
				end
			endcase
			program_phase(p);
			@(posedge clk);
			// hold the output back while items keep coming, so the input stalls
			if (p == 0)
				hold_go = ~hold_go;
			// open with a sample pair so a lowered period takes effect on it
			queue_item(edbs_pkg::OP_ECHO, pick_sample(), pick_sample());
			for (n = 1; n < PHASE_ITEMS; n++)
				queue_random_item();
			wait_idle();
		end

		if (mismatches == 0)
			$display("PASS echo_detect_blink_scheduler_core");
		else
			$display("FAIL echo_detect_blink_scheduler_core");
		$finish;
	end

endmodule

// File: files.f
rtl/edbs_pkg.sv
rtl/edbs_cfg.sv
rtl/edbs_lane.sv
rtl/edbs_sched.sv
rtl/echo_detect_blink_scheduler_core.sv
verif/tb_echo_detect_blink_scheduler_core.sv
